// ===== hw/rtl/btq_pkg.sv =====
// ----------------------------------------------------------------------------
// btq_pkg
// Shared codes and types of the bounded task queue: command modes, result
// status codes, life-cycle states and sequencer states.
// ----------------------------------------------------------------------------
package btq_pkg;

   localparam int SEQ_BITS    = 64;
   localparam int LIMIT_BITS  = 5;
   localparam int DEPTH_BITS  = 5;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic [2:0] {
      MODE_START       = 3'd0,
      MODE_POST        = 3'd1,
      MODE_POST_UNIQUE = 3'd2,
      MODE_BEGIN_STOP  = 3'd3,
      MODE_POP         = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_ACCEPTED = 3'd0,
      STATUS_STOPPING = 3'd1,
      STATUS_OVERFLOW = 3'd2,
      STATUS_REFUSED  = 3'd3,
      STATUS_DONE     = 3'd4,
      STATUS_TASK_OUT = 3'd5,
      STATUS_TEARDOWN = 3'd6,
      STATUS_IDLE     = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      LIFE_NEW       = 2'd0,
      LIFE_RUNNING   = 2'd1,
      LIFE_QUIESCING = 2'd2,
      LIFE_STOPPED   = 2'd3
   } life_type;

   typedef enum logic {
      SEQ_IDLE  = 1'b0,
      SEQ_FETCH = 1'b1
   } seq_state_type;

endpackage

// ===== hw/rtl/btq_ram.sv =====
// ----------------------------------------------------------------------------
// btq_ram
// Generic single-clock RAM with one write port and one read port; the read
// data is registered, so it appears in the cycle after the read request.
// ----------------------------------------------------------------------------
module btq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bounded_task_queue_with_drain.sv =====
// ----------------------------------------------------------------------------
// bounded_task_queue_with_drain
// Bounded FIFO of task tags under a new/running/quiescing/stopped life cycle.
//
// Each command beat on the req_ channel (mode, task_tag) yields exactly one
// result beat on the rsp_ channel. The queue entries (tag, sequence number and
// continuation mark) live in one RAM with a registered read port. Start,
// post, begin-stop, unknown modes and pops that find the queue empty
// complete in the accept cycle, and their result is valid on the next cycle,
// so they run at one beat per cycle while the receiver keeps up. A pop that
// hands out a task reads the head entry; req_ready is low during the read cycle.
// The result sits in an output register; a new command is accepted while a
// result waits only in the cycle in which that result is taken, so a stalled
// receiver holds off the request side.
// Reset empties the queue, sets the life state to new, restarts sequence
// numbers at 1 and sets max_pending to 16. csr_write_data is written to
// max_pending at any edge outside reset with csr_write_enable high.
// ----------------------------------------------------------------------------
module bounded_task_queue_with_drain #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_mode,
   input  logic [TAG_BITS-1:0] req_task_tag,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_status,
   output logic [63:0]         rsp_sequence_res,
   output logic [4:0]          rsp_overflow_depth,
   output logic [TAG_BITS-1:0] rsp_out_tag,
   output logic                rsp_cancelled,
   output logic [1:0]          rsp_exec_state,
   output logic [4:0]          rsp_pending_depth,
   input  logic                csr_write_enable,
   input  logic [4:0]          csr_write_data
);

   import btq_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_BITS = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;
   localparam int ENTRY_BITS = TAG_BITS + SEQ_BITS + 1;
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CMP_BITS-1:0] DEPTH_CMP = CMP_BITS'(QUEUE_DEPTH);

   seq_state_type         seq_state_ff, seq_state_in;
   life_type              life_ff, life_in;
   logic [PTR_BITS-1:0]   head_ff, head_in;
   logic [PTR_BITS-1:0]   tail_ff, tail_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [SEQ_BITS-1:0]   next_seq_ff, next_seq_in;
   logic                  cont_pending_ff, cont_pending_in;
   logic [SEQ_BITS-1:0]   cont_seq_ff, cont_seq_in;
   logic                  teardown_ff, teardown_in;
   logic [LIMIT_BITS-1:0] max_pending_ff;
   logic                  pop_cancel_ff, pop_cancel_in;

   logic                  rsp_valid_ff;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [SEQ_BITS-1:0]   rsp_seq_ff, rsp_seq_in;
   logic [DEPTH_BITS-1:0] rsp_odepth_ff, rsp_odepth_in;
   logic [TAG_BITS-1:0]   rsp_tag_ff, rsp_tag_in;
   logic                  rsp_cancel_ff, rsp_cancel_in;
   logic [1:0]            rsp_exec_ff, rsp_exec_in;
   logic [DEPTH_BITS-1:0] rsp_pending_ff, rsp_pending_in;

   logic                  accept;
   logic                  load;
   logic                  wr_en;
   logic                  rd_en;
   logic [ENTRY_BITS-1:0] wr_data;
   logic [ENTRY_BITS-1:0] rd_data;
   logic [CMP_BITS-1:0]   limit;
   logic                  full;

   assign req_ready = (seq_state_ff == SEQ_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign limit = (CMP_BITS'(max_pending_ff) > DEPTH_CMP) ? DEPTH_CMP
                                                           : CMP_BITS'(max_pending_ff);
   assign full  = CMP_BITS'(count_ff) >= limit;

   assign wr_data = {(req_mode == MODE_POST_UNIQUE), next_seq_ff, req_task_tag};

   btq_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(QUEUE_DEPTH),
      .ADDR_BITS(PTR_BITS)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(tail_ff),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(head_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      seq_state_in    = seq_state_ff;
      life_in         = life_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      next_seq_in     = next_seq_ff;
      cont_pending_in = cont_pending_ff;
      cont_seq_in     = cont_seq_ff;
      teardown_in     = teardown_ff;
      pop_cancel_in   = pop_cancel_ff;
      wr_en           = 1'b0;
      rd_en           = 1'b0;
      load            = 1'b0;
      rsp_status_in   = STATUS_REFUSED;
      rsp_seq_in      = '0;
      rsp_odepth_in   = '0;
      rsp_tag_in      = '0;
      rsp_cancel_in   = 1'b0;
      unique case (seq_state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               load = 1'b1;
               case (req_mode)
                  MODE_START: begin
                     if (life_ff == LIFE_NEW && max_pending_ff != '0) begin
                        life_in       = LIFE_RUNNING;
                        rsp_status_in = STATUS_DONE;
                     end
                  end
                  MODE_POST, MODE_POST_UNIQUE: begin
                     if (life_ff != LIFE_RUNNING) begin
                        rsp_status_in = STATUS_STOPPING;
                     end else if (req_mode == MODE_POST_UNIQUE && cont_pending_ff) begin
                        rsp_status_in = STATUS_ACCEPTED;
                        rsp_seq_in    = cont_seq_ff;
                     end else if (full) begin
                        rsp_status_in = STATUS_OVERFLOW;
                        rsp_odepth_in = DEPTH_BITS'(count_ff);
                     end else begin
                        wr_en         = 1'b1;
                        rsp_status_in = STATUS_ACCEPTED;
                        rsp_seq_in    = next_seq_ff;
                        next_seq_in   = next_seq_ff + 1'b1;
                        tail_in       = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
                        count_in      = count_ff + 1'b1;
                        if (req_mode == MODE_POST_UNIQUE) begin
                           cont_pending_in = 1'b1;
                           cont_seq_in     = next_seq_ff;
                        end
                     end
                  end
                  MODE_BEGIN_STOP: begin
                     if (life_ff == LIFE_RUNNING) begin
                        life_in       = LIFE_QUIESCING;
                        rsp_status_in = STATUS_DONE;
                     end
                  end
                  MODE_POP: begin
                     if (count_ff != '0) begin
                        load          = 1'b0;
                        rd_en         = 1'b1;
                        seq_state_in  = SEQ_FETCH;
                        pop_cancel_in = (life_ff == LIFE_QUIESCING);
                        head_in       = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
                        count_in      = count_ff - 1'b1;
                     end else if (life_ff == LIFE_QUIESCING && !teardown_ff) begin
                        teardown_in   = 1'b1;
                        life_in       = LIFE_STOPPED;
                        rsp_status_in = STATUS_TEARDOWN;
                     end else begin
                        rsp_status_in = STATUS_IDLE;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_REFUSED;
                  end
               endcase
            end
         end
         SEQ_FETCH: begin
            load          = 1'b1;
            seq_state_in  = SEQ_IDLE;
            rsp_status_in = STATUS_TASK_OUT;
            rsp_tag_in    = rd_data[TAG_BITS-1:0];
            rsp_seq_in    = rd_data[TAG_BITS +: SEQ_BITS];
            rsp_cancel_in = pop_cancel_ff;
            if (rd_data[ENTRY_BITS-1]) begin
               cont_pending_in = 1'b0;
               cont_seq_in     = '0;
            end
         end
         default: begin
            seq_state_in = SEQ_IDLE;
         end
      endcase
      rsp_exec_in    = life_in;
      rsp_pending_in = DEPTH_BITS'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff    <= SEQ_IDLE;
         life_ff         <= LIFE_NEW;
         head_ff         <= '0;
         tail_ff         <= '0;
         count_ff        <= '0;
         next_seq_ff     <= SEQ_BITS'(1);
         cont_pending_ff <= 1'b0;
         cont_seq_ff     <= '0;
         teardown_ff     <= 1'b0;
         max_pending_ff  <= LIMIT_RESET;
         pop_cancel_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         seq_state_ff    <= seq_state_in;
         life_ff         <= life_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         count_ff        <= count_in;
         next_seq_ff     <= next_seq_in;
         cont_pending_ff <= cont_pending_in;
         cont_seq_ff     <= cont_seq_in;
         teardown_ff     <= teardown_in;
         pop_cancel_ff   <= pop_cancel_in;
         if (csr_write_enable) begin
            max_pending_ff <= csr_write_data;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_seq_ff     <= rsp_seq_in;
         rsp_odepth_ff  <= rsp_odepth_in;
         rsp_tag_ff     <= rsp_tag_in;
         rsp_cancel_ff  <= rsp_cancel_in;
         rsp_exec_ff    <= rsp_exec_in;
         rsp_pending_ff <= rsp_pending_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_sequence_res   = rsp_seq_ff;
   assign rsp_overflow_depth = rsp_odepth_ff;
   assign rsp_out_tag        = rsp_tag_ff;
   assign rsp_cancelled      = rsp_cancel_ff;
   assign rsp_exec_state     = rsp_exec_ff;
   assign rsp_pending_depth  = rsp_pending_ff;

endmodule
